>>> sv/tgc_pkg.sv
// Shared types, constants and helpers for the touch gesture classifier.
package tgc_pkg;

    localparam int RAW_W       = 10;
    localparam int COORD_W     = 13;
    localparam int NUM_BUTTONS = 12;
    localparam int IDX_W       = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam int DEF_PANEL_WIDTH  = 540;
    localparam int DEF_PANEL_HEIGHT = 960;

    // Button bit positions
    localparam int KEY_BACK    = 0;
    localparam int KEY_CONFIRM = 1;
    localparam int KEY_LEFT    = 2;
    localparam int KEY_RIGHT   = 3;
    localparam int KEY_UP      = 4;
    localparam int KEY_DOWN    = 5;
    localparam int KEY_POWER   = 6;
    localparam int KEY_SWL     = 7;
    localparam int KEY_SWR     = 8;
    localparam int KEY_SWU     = 9;
    localparam int KEY_SWD     = 10;
    localparam int KEY_TWO     = 11;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOOTER_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SWIPE_ENABLE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HSWIPE_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DOMINANCE_MARGIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VSWIPE_THRESHOLD = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_DRIFT        = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_HOTSPOT    = 3'd7;

    // Orientation codes
    localparam logic [1:0] ORIENT_PORTRAIT = 2'd0;
    localparam logic [1:0] ORIENT_LAND_CW  = 2'd1;
    localparam logic [1:0] ORIENT_INVERTED = 2'd2;
    localparam logic [1:0] ORIENT_LAND_CCW = 2'd3;

    // Swipe direction codes
    localparam logic [1:0] SWIPE_NONE  = 2'd0;
    localparam logic [1:0] SWIPE_LEFT  = 2'd1;
    localparam logic [1:0] SWIPE_RIGHT = 2'd2;

    typedef logic [NUM_BUTTONS-1:0] btn_mask_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic             touching;
        logic [2:0]       point_count;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } in_word_t;

    typedef struct packed {
        btn_mask_t        button_mask;
        btn_mask_t        new_press_mask;
        logic [IDX_W-1:0] last_pressed;
        logic             content_tap_released;
        logic [RAW_W-1:0] content_tap_x;
        logic [RAW_W-1:0] content_tap_y;
    } out_word_t;

    typedef struct packed {
        logic [1:0]       orientation;
        logic [RAW_W-1:0] footer_height;
        logic             swipe_enable;
        logic [RAW_W-1:0] hswipe_threshold;
        logic [RAW_W-1:0] dominance_margin;
        logic [RAW_W-1:0] vswipe_threshold;
        logic [RAW_W-1:0] tap_drift;
        logic [RAW_W-1:0] power_hotspot;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        orientation:      ORIENT_PORTRAIT,
        footer_height:    10'd0,
        swipe_enable:     1'b1,
        hswipe_threshold: 10'd60,
        dominance_margin: 10'd20,
        vswipe_threshold: 10'd60,
        tap_drift:        10'd15,
        power_hotspot:    10'd60
    };

    // Zone lookup result for the start point
    typedef struct packed {
        btn_mask_t zone_mask;
        logic      in_content;
    } zone_info_t;

    function automatic coord_t to_coord(logic [RAW_W-1:0] v);
        return coord_t'({{(COORD_W-RAW_W){1'b0}}, v});
    endfunction

    function automatic coord_t abs_coord(coord_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [IDX_W-1:0] lowest_button(btn_mask_t m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> sv/tgc_rotate.sv
// Rotation of a raw portrait point into logical coordinates.
module tgc_rotate #(
    parameter int PANEL_WIDTH  = tgc_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = tgc_pkg::DEF_PANEL_HEIGHT
) (
    input  logic [1:0]                orientation,
    input  logic [tgc_pkg::RAW_W-1:0] raw_x,
    input  logic [tgc_pkg::RAW_W-1:0] raw_y,
    output tgc_pkg::coord_t           lx,
    output tgc_pkg::coord_t           ly
);
    import tgc_pkg::*;

    localparam coord_t W_MAX = coord_t'(PANEL_WIDTH - 1);
    localparam coord_t H_MAX = coord_t'(PANEL_HEIGHT - 1);

    coord_t x;
    coord_t y;

    assign x = to_coord(raw_x);
    assign y = to_coord(raw_y);

    always_comb
    begin
        case (orientation)
            ORIENT_LAND_CW:
            begin
                lx = H_MAX - y;
                ly = x;
            end
            ORIENT_INVERTED:
            begin
                lx = W_MAX - x;
                ly = H_MAX - y;
            end
            ORIENT_LAND_CCW:
            begin
                lx = y;
                ly = W_MAX - x;
            end
            default:
            begin
                lx = x;
                ly = y;
            end
        endcase
    end

endmodule

>>> sv/tgc_zone.sv
// Zone button lookup and content-area test for a logical start point.
module tgc_zone #(
    parameter int PANEL_WIDTH  = tgc_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = tgc_pkg::DEF_PANEL_HEIGHT
) (
    input  tgc_pkg::cfg_t       cfg,
    input  tgc_pkg::coord_t     lx,
    input  tgc_pkg::coord_t     ly,
    output tgc_pkg::zone_info_t info
);
    import tgc_pkg::*;

    localparam coord_t PW    = coord_t'(PANEL_WIDTH);
    localparam coord_t PH    = coord_t'(PANEL_HEIGHT);
    localparam coord_t Q_P   = coord_t'(PANEL_WIDTH / 4);
    localparam coord_t Q_L   = coord_t'(PANEL_HEIGHT / 4);
    localparam coord_t T1_P  = coord_t'(PANEL_WIDTH / 3);
    localparam coord_t T1_L  = coord_t'(PANEL_HEIGHT / 3);
    localparam coord_t T2_P  = coord_t'(PANEL_WIDTH * 2 / 3);
    localparam coord_t T2_L  = coord_t'(PANEL_HEIGHT * 2 / 3);

    coord_t w;
    coord_t h;
    coord_t q;
    coord_t t1;
    coord_t t2;
    coord_t fh;
    coord_t hs;
    coord_t footer_top;
    logic   on_screen;

    always_comb
    begin
        w          = cfg.orientation[0] ? PH : PW;
        h          = cfg.orientation[0] ? PW : PH;
        q          = cfg.orientation[0] ? Q_L : Q_P;
        t1         = cfg.orientation[0] ? T1_L : T1_P;
        t2         = cfg.orientation[0] ? T2_L : T2_P;
        fh         = to_coord(cfg.footer_height);
        hs         = to_coord(cfg.power_hotspot);
        footer_top = h - fh;
        on_screen  = (lx >= 0) && (lx < w) && (ly >= 0) && (ly < h);

        info.zone_mask  = '0;
        info.in_content = (lx >= 0) && (lx < w) && (ly >= 0) && (ly < footer_top);

        if (on_screen)
        begin
            if (fh != 0)
            begin
                if ((lx < hs) && (ly < hs))
                begin
                    info.zone_mask = btn_mask_t'(1) << KEY_POWER;
                end
                else if (ly >= footer_top)
                begin
                    if (lx < q)
                    begin
                        info.zone_mask = btn_mask_t'(1) << KEY_BACK;
                    end
                    else if (lx < (q <<< 1))
                    begin
                        info.zone_mask = btn_mask_t'(1) << KEY_CONFIRM;
                    end
                    else if (lx < (q + (q <<< 1)))
                    begin
                        info.zone_mask = btn_mask_t'(1) << KEY_LEFT;
                    end
                    else
                    begin
                        info.zone_mask = btn_mask_t'(1) << KEY_RIGHT;
                    end
                end
            end
            else if (lx < t1)
            begin
                info.zone_mask = btn_mask_t'(1) << KEY_LEFT;
            end
            else if (lx >= t2)
            begin
                info.zone_mask = btn_mask_t'(1) << KEY_RIGHT;
            end
            else
            begin
                info.zone_mask = btn_mask_t'(1) << KEY_CONFIRM;
            end
        end
    end

endmodule

>>> sv/tgc_classify.sv
// Touch sequence tracking state and per-poll gesture classification.
module tgc_classify #(
    parameter int PANEL_WIDTH  = tgc_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = tgc_pkg::DEF_PANEL_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  tgc_pkg::cfg_t      cfg,
    input  tgc_pkg::in_word_t  word,
    output tgc_pkg::out_word_t result
);
    import tgc_pkg::*;

    logic             touch_active_reg, touch_active_next;
    logic             saw_multi_reg, saw_multi_next;
    logic             swipe_fired_reg, swipe_fired_next;
    logic [1:0]       swipe_dir_reg, swipe_dir_next;
    logic [RAW_W-1:0] start_x_reg, start_x_next;
    logic [RAW_W-1:0] start_y_reg, start_y_next;
    logic [RAW_W-1:0] last_x_reg, last_x_next;
    logic [RAW_W-1:0] last_y_reg, last_y_next;
    btn_mask_t        prev_mask_reg, prev_mask_next;
    logic [IDX_W-1:0] pressed_index_reg, pressed_index_next;
    logic [RAW_W-1:0] tap_x_reg, tap_x_next;
    logic [RAW_W-1:0] tap_y_reg, tap_y_next;

    logic             new_touch;
    logic [RAW_W-1:0] sel_start_x, sel_start_y;
    logic [RAW_W-1:0] sel_last_x, sel_last_y;
    coord_t           sx, sy, ex, ey, dx, dy, ax, ay;
    coord_t           td, vt, dm;
    logic             hswipe;
    zone_info_t       zone;
    btn_mask_t        mask, fresh;
    logic             tap_done;
    logic             fired_cur;
    logic [1:0]       dir_cur;

    // A poll that starts a sequence uses its own point as the start point
    assign new_touch   = word.touching && !touch_active_reg;
    assign sel_start_x = new_touch ? word.raw_x : start_x_reg;
    assign sel_start_y = new_touch ? word.raw_y : start_y_reg;
    assign sel_last_x  = word.touching ? word.raw_x : last_x_reg;
    assign sel_last_y  = word.touching ? word.raw_y : last_y_reg;

    tgc_rotate #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_rot_start (
        .orientation (cfg.orientation),
        .raw_x       (sel_start_x),
        .raw_y       (sel_start_y),
        .lx          (sx),
        .ly          (sy)
    );

    tgc_rotate #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_rot_last (
        .orientation (cfg.orientation),
        .raw_x       (sel_last_x),
        .raw_y       (sel_last_y),
        .lx          (ex),
        .ly          (ey)
    );

    tgc_zone #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_zone (
        .cfg  (cfg),
        .lx   (sx),
        .ly   (sy),
        .info (zone)
    );

    assign dx     = ex - sx;
    assign dy     = ey - sy;
    assign ax     = abs_coord(dx);
    assign ay     = abs_coord(dy);
    assign td     = to_coord(cfg.tap_drift);
    assign vt     = to_coord(cfg.vswipe_threshold);
    assign dm     = to_coord(cfg.dominance_margin);
    assign hswipe = (ax >= to_coord(cfg.hswipe_threshold)) && (ax >= (ay + dm));

    always_comb
    begin
        touch_active_next = touch_active_reg;
        saw_multi_next    = saw_multi_reg;
        swipe_fired_next  = swipe_fired_reg;
        swipe_dir_next    = swipe_dir_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;
        tap_x_next        = tap_x_reg;
        tap_y_next        = tap_y_reg;
        mask              = '0;
        tap_done          = 1'b0;
        fired_cur         = new_touch ? 1'b0 : swipe_fired_reg;
        dir_cur           = new_touch ? SWIPE_NONE : swipe_dir_reg;

        if (word.touching)
        begin
            last_x_next       = word.raw_x;
            last_y_next       = word.raw_y;
            saw_multi_next    = saw_multi_reg || (word.point_count >= 3'd2);
            touch_active_next = 1'b1;
            if (new_touch)
            begin
                start_x_next = word.raw_x;
                start_y_next = word.raw_y;
            end
            swipe_fired_next = fired_cur;
            swipe_dir_next   = dir_cur;
            // Early horizontal swipe, reader mode only
            if ((cfg.footer_height == '0) && !saw_multi_next && !fired_cur && hswipe)
            begin
                swipe_fired_next = 1'b1;
                swipe_dir_next   = (dx < 0) ? SWIPE_LEFT : SWIPE_RIGHT;
            end
            if (swipe_fired_next && cfg.swipe_enable)
            begin
                if (swipe_dir_next == SWIPE_LEFT)
                begin
                    mask[KEY_SWL] = 1'b1;
                end
                else if (swipe_dir_next == SWIPE_RIGHT)
                begin
                    mask[KEY_SWR] = 1'b1;
                end
            end
        end
        else if (touch_active_reg)
        begin
            touch_active_next = 1'b0;
            if (cfg.footer_height != '0)
            begin
                if (zone.zone_mask != '0)
                begin
                    mask = zone.zone_mask;
                end
                else if (!saw_multi_reg && zone.in_content &&
                         (dx >= -td) && (dx <= td) && (dy >= -td) && (dy <= td))
                begin
                    tap_x_next = sx[RAW_W-1:0];
                    tap_y_next = sy[RAW_W-1:0];
                    tap_done   = 1'b1;
                end
            end
            else if (saw_multi_reg)
            begin
                mask[KEY_BACK] = 1'b1;
                mask[KEY_TWO]  = 1'b1;
            end
            else if (swipe_fired_reg)
            begin
                // reported while the finger was down
                mask = '0;
            end
            else if (hswipe)
            begin
                if (cfg.swipe_enable)
                begin
                    if (dx < 0)
                    begin
                        mask[KEY_SWL] = 1'b1;
                    end
                    else
                    begin
                        mask[KEY_SWR] = 1'b1;
                    end
                end
            end
            else if ((dy < -vt) && (ay >= (ax + dm)))
            begin
                mask[KEY_SWU] = 1'b1;
                mask[KEY_UP]  = 1'b1;
            end
            else if ((dy > vt) && (ay >= (ax + dm)))
            begin
                mask[KEY_SWD]  = 1'b1;
                mask[KEY_DOWN] = 1'b1;
            end
            else
            begin
                mask = zone.zone_mask;
            end
            saw_multi_next   = 1'b0;
            swipe_fired_next = 1'b0;
            swipe_dir_next   = SWIPE_NONE;
        end

        fresh              = mask & ~prev_mask_reg;
        pressed_index_next = (fresh != '0) ? lowest_button(fresh) : pressed_index_reg;
        prev_mask_next     = mask;

        result.button_mask          = mask;
        result.new_press_mask       = fresh;
        result.last_pressed         = pressed_index_next;
        result.content_tap_released = tap_done;
        result.content_tap_x        = tap_x_next;
        result.content_tap_y        = tap_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_active_reg  <= 1'b0;
            saw_multi_reg     <= 1'b0;
            swipe_fired_reg   <= 1'b0;
            swipe_dir_reg     <= SWIPE_NONE;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            last_x_reg        <= '0;
            last_y_reg        <= '0;
            prev_mask_reg     <= '0;
            pressed_index_reg <= '0;
            tap_x_reg         <= '0;
            tap_y_reg         <= '0;
        end
        else if (advance)
        begin
            touch_active_reg  <= touch_active_next;
            saw_multi_reg     <= saw_multi_next;
            swipe_fired_reg   <= swipe_fired_next;
            swipe_dir_reg     <= swipe_dir_next;
            start_x_reg       <= start_x_next;
            start_y_reg       <= start_y_next;
            last_x_reg        <= last_x_next;
            last_y_reg        <= last_y_next;
            prev_mask_reg     <= prev_mask_next;
            pressed_index_reg <= pressed_index_next;
            tap_x_reg         <= tap_x_next;
            tap_y_reg         <= tap_y_next;
        end
    end

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !touch_active_reg |-> (!swipe_fired_reg && !saw_multi_reg))
        else $error("sequence flags set without an active touch");

    a_dir_matches_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (swipe_dir_reg != SWIPE_NONE) == swipe_fired_reg)
        else $error("swipe direction out of step with swipe flag");

    a_tap_no_button: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tap_done) |-> (mask == '0))
        else $error("content tap reported together with a button");

endmodule

>>> sv/touch_gesture_classifier.sv
// Top level: configuration registers, poll input stage and result output register.
// A poll is first held in the stage register; its result word is then registered in the result register.
// Throughput: one poll per cycle while the result side is not stalled.
// The result register frees the input side while a result waits to be taken.
// Reset (rst_n low, asynchronous) empties both stages, clears all tracking state
// and returns the configuration registers to their defaults.
module touch_gesture_classifier #(
    parameter int PANEL_WIDTH  = tgc_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = tgc_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tgc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           poll_valid,
    output logic                           poll_ready,
    input  tgc_pkg::in_word_t              poll,
    output logic                           result_valid,
    input  logic                           result_ready,
    output tgc_pkg::out_word_t             result
);
    import tgc_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      stage_valid_reg, stage_valid_next;
    in_word_t  stage_reg;
    logic      result_valid_reg, result_valid_next;
    out_word_t result_reg;
    out_word_t step_word;
    logic      advance;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIENTATION:      cfg_next.orientation      = cfg_data[1:0];
                REG_FOOTER_HEIGHT:    cfg_next.footer_height    = cfg_data;
                REG_SWIPE_ENABLE:     cfg_next.swipe_enable     = cfg_data[0];
                REG_HSWIPE_THRESHOLD: cfg_next.hswipe_threshold = cfg_data;
                REG_DOMINANCE_MARGIN: cfg_next.dominance_margin = cfg_data;
                REG_VSWIPE_THRESHOLD: cfg_next.vswipe_threshold = cfg_data;
                REG_TAP_DRIFT:        cfg_next.tap_drift        = cfg_data;
                REG_POWER_HOTSPOT:    cfg_next.power_hotspot    = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Advance the stage word when the result register is free or being drained
    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign poll_ready = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (poll_valid && poll_ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    tgc_classify #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .word    (stage_reg),
        .result  (step_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg          <= CFG_RESET;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && poll_ready)
        begin
            stage_reg <= poll;
        end
        if (advance)
        begin
            result_reg <= step_word;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> poll_ready)
        else $error("input held off with an empty stage");

    a_fresh_subset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.new_press_mask & ~result.button_mask) == '0))
        else $error("new press outside button mask");

    a_lowest_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.new_press_mask != '0)) |->
        (((result.new_press_mask >> result.last_pressed) & btn_mask_t'(1)) != '0) &&
        ((result.new_press_mask & ((btn_mask_t'(1) << result.last_pressed) - btn_mask_t'(1)))
            == '0))
        else $error("last pressed is not the lowest new press");

endmodule

>>> bench/touch_gesture_classifier_test.sv
// Self-checking testbench for the touch gesture classifier: directed and random touch sequences vs. a predictor.
module touch_gesture_classifier_test;
    import tgc_pkg::*;

    localparam int PANEL_W      = DEF_PANEL_WIDTH;
    localparam int PANEL_H      = DEF_PANEL_HEIGHT;
    localparam int RANDOM_POLLS = 1950;
    localparam int PHASES       = 10;
    localparam int CYCLE_LIMIT  = 400000;

    class gesture_scoreboard;
        cfg_t             cfg;
        bit               touch_active;
        bit               saw_multi;
        bit               swipe_fired;
        logic [1:0]       swipe_dir;
        logic [RAW_W-1:0] start_x, start_y, last_x, last_y, tap_x, tap_y;
        btn_mask_t        prev_mask;
        logic [IDX_W-1:0] pressed_index;
        out_word_t        expected_words[$];
        int               errors;

        function new();
            cfg = CFG_RESET;
            touch_active = 0;
            saw_multi = 0;
            swipe_fired = 0;
            swipe_dir = SWIPE_NONE;
            start_x = '0;
            start_y = '0;
            last_x = '0;
            last_y = '0;
            tap_x = '0;
            tap_y = '0;
            prev_mask = '0;
            pressed_index = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ORIENTATION:      cfg.orientation = data[1:0];
                REG_FOOTER_HEIGHT:    cfg.footer_height = data;
                REG_SWIPE_ENABLE:     cfg.swipe_enable = data[0];
                REG_HSWIPE_THRESHOLD: cfg.hswipe_threshold = data;
                REG_DOMINANCE_MARGIN: cfg.dominance_margin = data;
                REG_VSWIPE_THRESHOLD: cfg.vswipe_threshold = data;
                REG_TAP_DRIFT:        cfg.tap_drift = data;
                REG_POWER_HOTSPOT:    cfg.power_hotspot = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void rotate(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                             output int lx, output int ly);
            int x, y;
            x = rx;
            y = ry;
            case (cfg.orientation)
                ORIENT_LAND_CW:
                begin
                    lx = PANEL_H - 1 - y;
                    ly = x;
                end
                ORIENT_INVERTED:
                begin
                    lx = PANEL_W - 1 - x;
                    ly = PANEL_H - 1 - y;
                end
                ORIENT_LAND_CCW:
                begin
                    lx = y;
                    ly = PANEL_W - 1 - x;
                end
                default:
                begin
                    lx = x;
                    ly = y;
                end
            endcase
        endfunction

        function int screen_w();
            return cfg.orientation[0] ? PANEL_H : PANEL_W;
        endfunction

        function int screen_h();
            return cfg.orientation[0] ? PANEL_W : PANEL_H;
        endfunction

        // Button for a tap that starts at this raw point, or -1 when none applies.
        function int zone_button(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry);
            int lx, ly, w, h, fh, hs, q;
            rotate(rx, ry, lx, ly);
            w = screen_w();
            h = screen_h();
            fh = cfg.footer_height;
            hs = cfg.power_hotspot;
            if (lx < 0 || lx >= w || ly < 0 || ly >= h)
                return -1;
            if (fh > 0)
            begin
                if (lx < hs && ly < hs)
                    return KEY_POWER;
                if (ly >= h - fh)
                begin
                    q = w / 4;
                    if (lx < q)
                        return KEY_BACK;
                    if (lx < q * 2)
                        return KEY_CONFIRM;
                    if (lx < q * 3)
                        return KEY_LEFT;
                    return KEY_RIGHT;
                end
                return -1;
            end
            if (lx < w / 3)
                return KEY_LEFT;
            if (lx >= w * 2 / 3)
                return KEY_RIGHT;
            return KEY_CONFIRM;
        endfunction

        function void travel(output int dx, output int dy, output int sx, output int sy);
            int ex, ey;
            rotate(start_x, start_y, sx, sy);
            rotate(last_x, last_y, ex, ey);
            dx = ex - sx;
            dy = ey - sy;
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function bit is_hswipe(int dx, int dy);
            return magnitude(dx) >= int'(cfg.hswipe_threshold) &&
                   magnitude(dx) >= magnitude(dy) + int'(cfg.dominance_margin);
        endfunction

        function void note_poll(in_word_t p);
            btn_mask_t mask, fresh;
            bit        tap_done;
            int        dx, dy, sx, sy, ax, ay, b, td, vt, dm, i;
            out_word_t e;
            mask = '0;
            tap_done = 0;
            if (p.touching)
            begin
                last_x = p.raw_x;
                last_y = p.raw_y;
                if (p.point_count >= 2)
                    saw_multi = 1;
                if (!touch_active)
                begin
                    touch_active = 1;
                    start_x = last_x;
                    start_y = last_y;
                    swipe_fired = 0;
                    swipe_dir = SWIPE_NONE;
                end
                if (cfg.footer_height == 0 && !saw_multi && !swipe_fired)
                begin
                    travel(dx, dy, sx, sy);
                    if (is_hswipe(dx, dy))
                    begin
                        swipe_fired = 1;
                        swipe_dir = (dx < 0) ? SWIPE_LEFT : SWIPE_RIGHT;
                    end
                end
                if (swipe_fired && cfg.swipe_enable)
                begin
                    if (swipe_dir == SWIPE_LEFT)
                        mask[KEY_SWL] = 1'b1;
                    else if (swipe_dir == SWIPE_RIGHT)
                        mask[KEY_SWR] = 1'b1;
                end
            end
            else if (touch_active)
            begin
                touch_active = 0;
                if (cfg.footer_height != 0)
                begin
                    b = zone_button(start_x, start_y);
                    if (b >= 0)
                        mask[b] = 1'b1;
                    else if (!saw_multi)
                    begin
                        td = cfg.tap_drift;
                        travel(dx, dy, sx, sy);
                        if (sx >= 0 && sx < screen_w() && sy >= 0 &&
                            sy < screen_h() - int'(cfg.footer_height) &&
                            dx >= -td && dx <= td && dy >= -td && dy <= td)
                        begin
                            tap_x = sx[RAW_W-1:0];
                            tap_y = sy[RAW_W-1:0];
                            tap_done = 1;
                        end
                    end
                end
                else if (saw_multi)
                begin
                    mask[KEY_BACK] = 1'b1;
                    mask[KEY_TWO] = 1'b1;
                end
                else if (!swipe_fired)
                begin
                    // no early swipe fired; one that had would have been reported while the finger was down
                    travel(dx, dy, sx, sy);
                    ax = magnitude(dx);
                    ay = magnitude(dy);
                    vt = cfg.vswipe_threshold;
                    dm = cfg.dominance_margin;
                    if (is_hswipe(dx, dy))
                    begin
                        if (cfg.swipe_enable)
                            mask[(dx < 0) ? KEY_SWL : KEY_SWR] = 1'b1;
                    end
                    else if (dy < -vt && ay >= ax + dm)
                    begin
                        mask[KEY_SWU] = 1'b1;
                        mask[KEY_UP] = 1'b1;
                    end
                    else if (dy > vt && ay >= ax + dm)
                    begin
                        mask[KEY_SWD] = 1'b1;
                        mask[KEY_DOWN] = 1'b1;
                    end
                    else
                    begin
                        b = zone_button(start_x, start_y);
                        if (b >= 0)
                            mask[b] = 1'b1;
                    end
                end
                saw_multi = 0;
                swipe_fired = 0;
                swipe_dir = SWIPE_NONE;
            end

            fresh = mask & ~prev_mask;
            for (i = NUM_BUTTONS - 1; i >= 0; i--)
            begin
                if (fresh[i])
                    pressed_index = i[IDX_W-1:0];
            end
            prev_mask = mask;

            e.button_mask = mask;
            e.new_press_mask = fresh;
            e.last_pressed = pressed_index;
            e.content_tap_released = tap_done;
            e.content_tap_x = tap_x;
            e.content_tap_y = tap_y;
            expected_words.push_back(e);
        endfunction

        function void compare_field(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_word_t r);
            out_word_t e;
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word expected none got %h", $time, r);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            compare_field("button_mask", e.button_mask, r.button_mask);
            compare_field("new_press_mask", e.new_press_mask, r.new_press_mask);
            compare_field("last_pressed", e.last_pressed, r.last_pressed);
            compare_field("content_tap_released", e.content_tap_released,
                          r.content_tap_released);
            compare_field("content_tap_x", e.content_tap_x, r.content_tap_x);
            compare_field("content_tap_y", e.content_tap_y, r.content_tap_y);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   poll_valid;
    logic                   poll_ready;
    in_word_t               poll;
    logic                   result_valid;
    logic                   result_ready;
    out_word_t              result;

    gesture_scoreboard board;
    int                polls_sent;
    bit                quiet_tail;
    int unsigned       cycle_count;

    touch_gesture_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result);
    end

    // Result side: random stall bursts, none in the closing phase.
    initial
    begin
        int stall_left;
        result_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic logic [RAW_W-1:0] to_raw(int v);
        if (v < 0)
            return '0;
        if (v > 1023)
            return '1;
        return v[RAW_W-1:0];
    endfunction

    function automatic in_word_t make_poll(bit touching, int count, int x, int y);
        in_word_t w;
        w.touching = touching;
        w.point_count = 3'(count);
        w.raw_x = to_raw(x);
        w.raw_y = to_raw(y);
        return w;
    endfunction

    function automatic int offset(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int corner_coord(int size);
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 80);
        return size - 1 - int'($urandom_range(0, 80));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level(int typical);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 10'd960;
            2: return '1;
            default: return 10'($urandom_range(0, typical));
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.orientation = 2'($urandom_range(0, 3));
        c.footer_height = ($urandom_range(0, 1) == 0) ? 10'd0 : pick_level(300);
        c.swipe_enable = ($urandom_range(0, 3) != 0);
        c.hswipe_threshold = pick_level(150);
        c.dominance_margin = pick_level(60);
        c.vswipe_threshold = pick_level(150);
        c.tap_drift = pick_level(40);
        c.power_hotspot = pick_level(200);
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_poll(in_word_t w);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            poll_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        poll <= w;
        poll_valid <= 1'b1;
        do @(posedge clk); while (!poll_ready);
        board.note_poll(w);
        polls_sent++;
        @(negedge clk);
    endtask

    task automatic lift_finger();
        send_poll(make_poll(1'b0, $urandom_range(0, 7), $urandom_range(0, 1023),
                            $urandom_range(0, 1023)));
    endtask

    // Drop valid and hold off until every expected result word is back.
    task automatic drain();
        poll_valid <= 1'b0;
        do @(negedge clk); while (board.pending() != 0);
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_write <= 1'b1;
        board.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic load_settings(cfg_t c);
        put_reg(REG_ORIENTATION, 10'(c.orientation));
        put_reg(REG_FOOTER_HEIGHT, c.footer_height);
        put_reg(REG_SWIPE_ENABLE, 10'(c.swipe_enable));
        put_reg(REG_HSWIPE_THRESHOLD, c.hswipe_threshold);
        put_reg(REG_DOMINANCE_MARGIN, c.dominance_margin);
        put_reg(REG_VSWIPE_THRESHOLD, c.vswipe_threshold);
        put_reg(REG_TAP_DRIFT, c.tap_drift);
        put_reg(REG_POWER_HOTSPOT, c.power_hotspot);
        cfg_write <= 1'b0;
    endtask

    // Touching polls along a line from start to end, then optionally a lift.
    task automatic stroke(int sx, int sy, int ex, int ey, int steps, bit multi, bit lift);
        int k, x, y, multi_at, count;
        multi_at = multi ? int'($urandom_range(0, steps - 1)) : -1;
        for (k = 0; k < steps; k++)
        begin
            x = sx;
            y = sy;
            if (k > 0)
            begin
                x = sx + (ex - sx) * k / (steps - 1) + offset(2);
                y = sy + (ey - sy) * k / (steps - 1) + offset(2);
            end
            if (k == multi_at)
                count = $urandom_range(2, 7);
            else
                count = ($urandom_range(0, 15) == 0) ? 0 : 1;
            send_poll(make_poll(1'b1, count, x, y));
        end
        if (lift)
            lift_finger();
    endtask

    task automatic play_gesture();
        int          sx, sy, reach;
        logic [31:0] bits;
        case ($urandom_range(0, 8))
            0, 1:
            begin
                sx = corner_coord(PANEL_W);
                sy = corner_coord(PANEL_H);
            end
            2:
            begin
                sx = $urandom_range(0, 1023);
                sy = $urandom_range(0, 1023);
            end
            default:
            begin
                sx = $urandom_range(0, PANEL_W - 1);
                sy = $urandom_range(0, PANEL_H - 1);
            end
        endcase
        reach = $urandom_range(0, 300);
        if ($urandom_range(0, 1) == 0)
            reach = -reach;
        case ($urandom_range(0, 14))
            0:
            begin
                bits = $urandom;
                send_poll(in_word_t'(bits[$bits(in_word_t)-1:0]));
            end
            1, 2, 3, 4:
                stroke(sx, sy, sx + offset(20), sy + offset(20), $urandom_range(1, 4), 0, 1);
            5, 6, 7:
                stroke(sx, sy, sx + reach, sy + offset(40), $urandom_range(2, 6), 0, 1);
            8, 9:
                stroke(sx, sy, sx + offset(40), sy + reach, $urandom_range(2, 6), 0, 1);
            10:
                stroke(sx, sy, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(2, 6), 0, 1);
            11, 12:
                stroke(sx, sy, sx + offset(20), sy + offset(20), $urandom_range(1, 4), 1, 1);
            13:
                // leave the finger down; the next gesture continues this sequence
                stroke(sx, sy, sx + offset(30), sy + offset(30), $urandom_range(1, 3),
                       1'($urandom_range(0, 1)), 0);
            default:
                lift_finger();
        endcase
    endtask

    initial
    begin
        cfg_t settings;
        int   phase, target;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        poll_valid = 1'b0;
        poll = '0;
        polls_sent = 0;
        quiet_tail = 0;
        board = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reader mode, portrait, default thresholds
        send_poll(make_poll(1'b0, 5, 300, 300));
        send_poll(make_poll(1'b1, 1, 270, 480));
        lift_finger();
        send_poll(make_poll(1'b1, 1, 0, 0));
        lift_finger();
        send_poll(make_poll(1'b1, 1, 100, 500));
        send_poll(make_poll(1'b1, 1, 220, 505));
        lift_finger();
        send_poll(make_poll(1'b1, 1, 270, 800));
        send_poll(make_poll(1'b1, 1, 272, 600));
        lift_finger();
        send_poll(make_poll(1'b1, 1, 539, 100));
        send_poll(make_poll(1'b1, 1, 535, 300));
        lift_finger();
        send_poll(make_poll(1'b1, 2, 270, 480));
        lift_finger();
        send_poll(make_poll(1'b1, 7, 1023, 1023));
        lift_finger();

        // footer mode: power hotspot, footer zone, content tap, multi-touch on a zone
        drain();
        settings = CFG_RESET;
        settings.footer_height = 10'd100;
        load_settings(settings);
        send_poll(make_poll(1'b1, 1, 5, 5));
        lift_finger();
        send_poll(make_poll(1'b1, 1, 10, 959));
        lift_finger();
        send_poll(make_poll(1'b1, 1, 300, 400));
        send_poll(make_poll(1'b1, 1, 305, 396));
        lift_finger();
        send_poll(make_poll(1'b1, 5, 500, 950));
        lift_finger();

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase == 0)
                settings = '0;
            else if (phase == 1)
                settings = '{orientation: ORIENT_LAND_CCW, footer_height: 10'd960,
                             swipe_enable: 1'b1, hswipe_threshold: 10'd960,
                             dominance_margin: 10'd960, vswipe_threshold: 10'd960,
                             tap_drift: 10'd960, power_hotspot: 10'd960};
            else
                settings = random_settings();
            load_settings(settings);
            if (phase == PHASES - 1)
                quiet_tail = 1;
            target = polls_sent + RANDOM_POLLS / PHASES;
            while (polls_sent < target)
                play_gesture();
        end

        drain();
        repeat (4) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
sv/tgc_pkg.sv
sv/tgc_rotate.sv
sv/tgc_zone.sv
sv/tgc_classify.sv
sv/touch_gesture_classifier.sv
bench/touch_gesture_classifier_test.sv
